// ===== hdl/rfl_pkg.sv =====
// ----------------------------------------------------------------------------
// rfl_pkg: shared types and constants for the record field layout block
// Command and result records, status codes and a small helper function.
// ----------------------------------------------------------------------------
`default_nettype none

package rfl_pkg;

  localparam int unsigned SizeW    = 16;
  localparam int unsigned AlignW   = 13;
  localparam int unsigned ClsW     = 4;
  localparam int unsigned NumCls   = 13;
  localparam int unsigned RunW     = 23;
  localparam int unsigned OfsW     = 22;
  localparam int unsigned IndexW   = 6;
  localparam int unsigned CountW   = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;

  localparam logic [CfgIdxW-1:0] CfgOptimize = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxAlign = 2'd1;

  localparam logic OpAppend = 1'b0;
  localparam logic OpFinish = 1'b1;

  localparam logic [AlignW-1:0] MaxAlignReset = 13'd16;
  localparam logic [RunW-1:0]   HeaderBytes   = 23'd4;
  localparam logic [OfsW-1:0]   OfsMax        = 22'h3FFFFF;
  localparam logic [OfsW-1:0]   TotalMax      = 22'h3FFFF8;
  localparam logic [OfsW-1:0]   EmptyTotal    = 22'd8;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StBadAlign = 2'd1,
    StTooMany  = 2'd2
  } status_e;

  // One entry of the queue between the front and the back.
  typedef struct packed {
    logic               kind;
    logic [SizeW-1:0]   size;
    logic [ClsW-1:0]    cls;
    logic               raw_safe;
    status_e            status;
    logic [CountW-1:0]  count;
    logic               optimize;
    logic [NumCls-1:0]  cls_mask;
  } cmd_t;

  // One stored field descriptor.
  typedef struct packed {
    logic [SizeW-1:0] size;
    logic [ClsW-1:0]  cls;
    logic             raw_safe;
  } desc_t;

  // One result item.
  typedef struct packed {
    logic [IndexW-1:0] field_index;
    logic [OfsW-1:0]   field_offset;
    logic              needs_custom_copy;
    logic [OfsW-1:0]   total_size;
    logic [CountW-1:0] field_count;
    status_e           status;
    logic              last;
  } res_t;

  // Index of the highest set bit of a 13-bit mask (0 when the mask is empty).
  function automatic logic [ClsW-1:0] msb_index(input logic [NumCls-1:0] m);
    logic [ClsW-1:0] r;
    r = '0;
    for (int i = 0; i < NumCls; i++) begin
      if (m[i]) begin
        r = ClsW'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/record_field_layout.sv =====
// An append passes through the front end and the command queue into the back end. A finish
// places its fields (with optimize set, in one walk per alignment class present), rounds the
// total and then emits one result per field in load order. Error and empty finishes answer
// with a single result. Output stalls delay all of these.
// Throughput: one append per cycle while the input is not stalled; one finish at a time.
// Reset: asynchronous and active low; the layout is cleared, optimize is 0, max_align is 16.
// ----------------------------------------------------------------------------
// record_field_layout: record layout engine with alignment padding
// Takes field descriptors one by one and, on a finish item, reports the byte
// offset of every field, the padded record size and a status code.
// ----------------------------------------------------------------------------
`default_nettype none

module record_field_layout #(
  parameter int unsigned MAX_FIELDS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  // Configuration write channel.
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [rfl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [rfl_pkg::CfgDataW-1:0]  cfg_data_i,

  // Input item channel.
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          in_op_i,
  input  wire logic [rfl_pkg::SizeW-1:0]     in_field_size_i,
  input  wire logic [rfl_pkg::AlignW-1:0]    in_field_align_i,
  input  wire logic                          in_raw_copy_safe_i,

  // Result channel.
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [rfl_pkg::IndexW-1:0]         out_field_index_o,
  output logic [rfl_pkg::OfsW-1:0]           out_field_offset_o,
  output logic                               out_needs_custom_copy_o,
  output logic [rfl_pkg::OfsW-1:0]           out_total_size_o,
  output logic [rfl_pkg::CountW-1:0]         out_field_count_o,
  output logic [1:0]                         out_status_o,
  output logic                               out_last_o
);

  // The front end owns the configuration registers and the per-layout
  // bookkeeping: it counts descriptors, drops the ones beyond capacity and
  // keeps a mask of the alignment classes seen, plus a flag for any
  // alignment that is not a power of two. The alignment check against
  // max_align is therefore made once, at finish time, from that mask.
  //
  // Each transfer that does real work becomes a command in a two-entry
  // queue. The back end writes appended descriptors into its descriptor
  // memory and, on a finish command, walks that memory once per alignment
  // class (or once in load order), storing each field's offset in an offset
  // memory. A second walk in load order then emits one result per field.

  logic          push;
  logic          pop;
  logic          full;
  logic          cmd_valid;
  rfl_pkg::cmd_t cmd_in;
  rfl_pkg::cmd_t cmd_out;
  rfl_pkg::res_t res;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  rfl_front #(
    .MAX_FIELDS (MAX_FIELDS)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_op_i            (in_op_i),
    .in_field_size_i    (in_field_size_i),
    .in_field_align_i   (in_field_align_i),
    .in_raw_copy_safe_i (in_raw_copy_safe_i),
    .full_i             (full),
    .push_o             (push),
    .cmd_o              (cmd_in)
  );

  rfl_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_out)
  );

  rfl_back #(
    .MAX_FIELDS (MAX_FIELDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  // The result register in the back end drives the payload ports directly.
  assign out_field_index_o       = res.field_index;
  assign out_field_offset_o      = res.field_offset;
  assign out_needs_custom_copy_o = res.needs_custom_copy;
  assign out_total_size_o        = res.total_size;
  assign out_field_count_o       = res.field_count;
  assign out_status_o            = res.status;
  assign out_last_o              = res.last;

endmodule

`default_nettype wire

// ===== hdl/rfl_front.sv =====
// ----------------------------------------------------------------------------
// rfl_front: input side of the record field layout block
// Holds the configuration, counts and classifies descriptors, builds commands.
// ----------------------------------------------------------------------------
`default_nettype none

module rfl_front #(
  parameter int unsigned MAX_FIELDS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [rfl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [rfl_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          in_op_i,
  input  wire logic [rfl_pkg::SizeW-1:0]     in_field_size_i,
  input  wire logic [rfl_pkg::AlignW-1:0]    in_field_align_i,
  input  wire logic                          in_raw_copy_safe_i,
  input  wire logic                          full_i,
  output logic                               push_o,
  output rfl_pkg::cmd_t                      cmd_o
);

  localparam int unsigned CntW = $clog2(MAX_FIELDS + 1);

  logic                          optimize_q;
  logic [rfl_pkg::AlignW-1:0]    max_align_q;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic                          ovf_q, ovf_d;
  logic                          nonpow2_q, nonpow2_d;
  logic [rfl_pkg::NumCls-1:0]    cls_mask_q, cls_mask_d;

  logic                          accept;
  logic                          is_pow2;
  logic                          room;
  logic [rfl_pkg::NumCls-1:0]    allowed;
  logic                          too_big;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      optimize_q  <= 1'b0;
      max_align_q <= rfl_pkg::MaxAlignReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == rfl_pkg::CfgOptimize) begin
        optimize_q <= cfg_data_i[0];
      end else if (cfg_index_i == rfl_pkg::CfgMaxAlign) begin
        max_align_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    accept     = in_valid_i && !full_i;
    in_stall_o = full_i;
    is_pow2    = (in_field_align_i != '0) &&
                 ((in_field_align_i & (in_field_align_i - 13'd1)) == '0);
    room       = cnt_q < CntW'(MAX_FIELDS);

    for (int c = 0; c < rfl_pkg::NumCls; c++) begin
      allowed[c] = max_align_q >= (13'd1 << c);
    end
    too_big = |(cls_mask_q & ~allowed);

    cmd_o.kind     = in_op_i;
    cmd_o.size     = in_field_size_i;
    cmd_o.cls      = rfl_pkg::msb_index(in_field_align_i);
    cmd_o.raw_safe = in_raw_copy_safe_i;
    cmd_o.count    = rfl_pkg::CountW'(cnt_q);
    cmd_o.optimize = optimize_q;
    cmd_o.cls_mask = cls_mask_q;
    if (ovf_q) begin
      cmd_o.status = rfl_pkg::StTooMany;
    end else if (nonpow2_q || too_big) begin
      cmd_o.status = rfl_pkg::StBadAlign;
    end else begin
      cmd_o.status = rfl_pkg::StOk;
    end

    push_o = accept && ((in_op_i == rfl_pkg::OpFinish) || room);

    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    nonpow2_d  = nonpow2_q;
    cls_mask_d = cls_mask_q;
    if (accept) begin
      if (in_op_i == rfl_pkg::OpFinish) begin
        cnt_d      = '0;
        ovf_d      = 1'b0;
        nonpow2_d  = 1'b0;
        cls_mask_d = '0;
      end else if (room) begin
        cnt_d = cnt_q + CntW'(1);
        if (is_pow2) begin
          cls_mask_d = cls_mask_q | in_field_align_i;
        end else begin
          nonpow2_d = 1'b1;
        end
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      nonpow2_q  <= 1'b0;
      cls_mask_q <= '0;
    end else begin
      cnt_q      <= cnt_d;
      ovf_q      <= ovf_d;
      nonpow2_q  <= nonpow2_d;
      cls_mask_q <= cls_mask_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rfl_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// rfl_cmd_fifo: two-entry command queue
// Decouples the descriptor front end from the layout back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rfl_cmd_fifo (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  rfl_pkg::cmd_t data_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output logic         valid_o,
  output rfl_pkg::cmd_t data_o
);

  rfl_pkg::cmd_t mem_q [2];
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic [1:0]    cnt_q;

  always_comb begin
    full_o  = cnt_q == 2'd2;
    valid_o = cnt_q != 2'd0;
    data_o  = mem_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rfl_back.sv =====
// ----------------------------------------------------------------------------
// rfl_back: layout engine of the record field layout block
// Stores descriptors, places fields class by class or in load order and emits the results.
// ----------------------------------------------------------------------------
`default_nettype none

module rfl_back #(
  parameter int unsigned MAX_FIELDS = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cmd_valid_i,
  input  rfl_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output rfl_pkg::res_t res_o
);

  localparam int unsigned CntW = $clog2(MAX_FIELDS + 1);
  localparam int unsigned IdxW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;

  typedef enum logic [5:0] {
    BkIdle   = 6'b000001,
    BkPlace  = 6'b000010,
    BkTotal  = 6'b000100,
    BkEmitRd = 6'b001000,
    BkEmitLd = 6'b010000,
    BkEmitOne = 6'b100000
  } bk_state_e;

  bk_state_e                    state_q, state_d;
  logic [CntW-1:0]              wptr_q, wptr_d;
  logic [CntW-1:0]              n_q, n_d;
  rfl_pkg::status_e             status_q, status_d;
  logic                         opt_q, opt_d;
  logic [rfl_pkg::NumCls-1:0]   cls_left_q, cls_left_d;
  logic [rfl_pkg::ClsW-1:0]     cur_cls_q, cur_cls_d;
  logic [CntW-1:0]              addr_q, addr_d;
  logic                         rd_v_q, rd_v_d;
  logic [IdxW-1:0]              rd_idx_q, rd_idx_d;
  logic [rfl_pkg::ClsW-1:0]     rd_tag_q, rd_tag_d;
  logic [rfl_pkg::RunW-1:0]     ro_q, ro_d;
  logic [rfl_pkg::OfsW-1:0]     total_q, total_d;
  logic                         out_valid_q, out_valid_d;
  rfl_pkg::res_t                out_q, out_d;

  rfl_pkg::desc_t               desc_mem [MAX_FIELDS];
  logic [rfl_pkg::RunW-1:0]     ofs_mem [MAX_FIELDS];
  rfl_pkg::desc_t               desc_rdata_q;
  logic [rfl_pkg::RunW-1:0]     ofs_rdata_q;

  logic                         desc_we, desc_re, ofs_we, ofs_re;
  logic [IdxW-1:0]              desc_raddr;
  rfl_pkg::desc_t               desc_wdata;
  logic                         out_free;
  logic [rfl_pkg::RunW-1:0]     align_mask, aligned, ro_next;
  logic                         fit;
  logic [rfl_pkg::NumCls-1:0]   cls_rest;
  logic [rfl_pkg::RunW:0]       rounded;

  always_ff @(posedge clk_i) begin
    if (desc_we) begin
      desc_mem[wptr_q[IdxW-1:0]] <= desc_wdata;
    end
    if (desc_re) begin
      desc_rdata_q <= desc_mem[desc_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ofs_we) begin
      ofs_mem[rd_idx_q] <= aligned;
    end
    if (ofs_re) begin
      ofs_rdata_q <= ofs_mem[addr_q[IdxW-1:0]];
    end
  end

  always_comb begin
    state_d     = state_q;
    wptr_d      = wptr_q;
    n_d         = n_q;
    status_d    = status_q;
    opt_d       = opt_q;
    cls_left_d  = cls_left_q;
    cur_cls_d   = cur_cls_q;
    addr_d      = addr_q;
    rd_v_d      = rd_v_q;
    rd_idx_d    = rd_idx_q;
    rd_tag_d    = rd_tag_q;
    ro_d        = ro_q;
    total_d     = total_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    desc_we     = 1'b0;
    desc_re     = 1'b0;
    ofs_we      = 1'b0;
    ofs_re      = 1'b0;
    desc_raddr  = addr_q[IdxW-1:0];
    desc_wdata.size     = cmd_i.size;
    desc_wdata.cls      = cmd_i.cls;
    desc_wdata.raw_safe = cmd_i.raw_safe;

    out_free = !out_valid_q || !out_stall_i;

    // Round the running offset up to the field's alignment, then add its size.
    align_mask = (rfl_pkg::RunW'(1) << desc_rdata_q.cls) - rfl_pkg::RunW'(1);
    aligned    = (ro_q + align_mask) & ~align_mask;
    ro_next    = aligned + rfl_pkg::RunW'(desc_rdata_q.size);
    fit        = rd_v_q && (!opt_q || (desc_rdata_q.cls == rd_tag_q));
    cls_rest   = cls_left_q & ~(rfl_pkg::NumCls'(1) << cur_cls_q);
    rounded    = ({1'b0, ro_q} + 24'd7) & ~24'd7;

    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      BkIdle: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          if (cmd_i.kind == rfl_pkg::OpAppend) begin
            desc_we = 1'b1;
            wptr_d  = wptr_q + CntW'(1);
          end else begin
            wptr_d     = '0;
            n_d        = CntW'(cmd_i.count);
            status_d   = cmd_i.status;
            opt_d      = cmd_i.optimize;
            cls_left_d = cmd_i.cls_mask;
            cur_cls_d  = rfl_pkg::msb_index(cmd_i.cls_mask);
            addr_d     = '0;
            rd_v_d     = 1'b0;
            ro_d       = rfl_pkg::HeaderBytes;
            if ((cmd_i.status != rfl_pkg::StOk) || (cmd_i.count == '0)) begin
              state_d = BkEmitOne;
            end else begin
              state_d = BkPlace;
            end
          end
        end
      end

      BkPlace: begin
        if (fit) begin
          ofs_we = 1'b1;
          ro_d   = ro_next;
        end
        if (addr_q < n_q) begin
          desc_re  = 1'b1;
          rd_v_d   = 1'b1;
          rd_idx_d = addr_q[IdxW-1:0];
          rd_tag_d = cur_cls_q;
          addr_d   = addr_q + CntW'(1);
        end else begin
          rd_v_d = 1'b0;
          if (opt_q && (cls_rest != '0)) begin
            cls_left_d = cls_rest;
            cur_cls_d  = rfl_pkg::msb_index(cls_rest);
            addr_d     = '0;
          end else if (!rd_v_q) begin
            state_d = BkTotal;
          end
        end
      end

      BkTotal: begin
        if (rounded > {2'b00, rfl_pkg::TotalMax}) begin
          total_d = rfl_pkg::TotalMax;
        end else begin
          total_d = rounded[rfl_pkg::OfsW-1:0];
        end
        addr_d  = '0;
        state_d = BkEmitRd;
      end

      BkEmitRd: begin
        desc_re = 1'b1;
        ofs_re  = 1'b1;
        state_d = BkEmitLd;
      end

      BkEmitLd: begin
        if (out_free) begin
          out_valid_d             = 1'b1;
          out_d.field_index       = rfl_pkg::IndexW'(addr_q);
          out_d.field_offset      = (ofs_rdata_q > {1'b0, rfl_pkg::OfsMax}) ?
                                    rfl_pkg::OfsMax : ofs_rdata_q[rfl_pkg::OfsW-1:0];
          out_d.needs_custom_copy = ~desc_rdata_q.raw_safe;
          out_d.total_size        = total_q;
          out_d.field_count       = rfl_pkg::CountW'(n_q);
          out_d.status            = rfl_pkg::StOk;
          out_d.last              = (addr_q + CntW'(1)) == n_q;
          addr_d                  = addr_q + CntW'(1);
          state_d                 = ((addr_q + CntW'(1)) == n_q) ? BkIdle : BkEmitRd;
        end
      end

      BkEmitOne: begin
        if (out_free) begin
          out_valid_d             = 1'b1;
          out_d.field_index       = '0;
          out_d.field_offset      = '0;
          out_d.needs_custom_copy = 1'b0;
          out_d.total_size        = (status_q == rfl_pkg::StOk) ? rfl_pkg::EmptyTotal : '0;
          out_d.field_count       = rfl_pkg::CountW'(n_q);
          out_d.status            = status_q;
          out_d.last              = 1'b1;
          state_d                 = BkIdle;
        end
      end

      default: begin
        state_d = BkIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    status_q   <= status_d;
    opt_q      <= opt_d;
    cls_left_q <= cls_left_d;
    cur_cls_q  <= cur_cls_d;
    rd_idx_q   <= rd_idx_d;
    rd_tag_q   <= rd_tag_d;
    ro_q       <= ro_d;
    total_q    <= total_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      wptr_q      <= '0;
      addr_q      <= '0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wptr_q      <= wptr_d;
      addr_q      <= addr_d;
      rd_v_q      <= rd_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the record field layout engine
// Loads field descriptors and finish commands through the item channel,
// predicts every layout result inside the bench and compares each result
// transfer field by field, under random idling and back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumFields  = 32;
  localparam int unsigned TailCycles = 60;
  localparam int unsigned HoldCycles = 600;

  // Register indexes that select no register; writes to them must be dropped.
  localparam logic [rfl_pkg::CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [rfl_pkg::CfgIdxW-1:0] CfgSpareHi = 2'd3;

  // One item of the input channel.
  typedef struct {
    logic                       op;
    logic [rfl_pkg::SizeW-1:0]  size;
    logic [rfl_pkg::AlignW-1:0] align;
    logic                       raw_safe;
  } field_cmd_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the block.
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [rfl_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [rfl_pkg::CfgDataW-1:0] cfg_data  = '0;

  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_op    = rfl_pkg::OpAppend;
  logic [rfl_pkg::SizeW-1:0]  in_size  = '0;
  logic [rfl_pkg::AlignW-1:0] in_align = '0;
  logic                       in_raw   = 1'b0;

  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [rfl_pkg::IndexW-1:0] out_index;
  logic [rfl_pkg::OfsW-1:0]   out_offset;
  logic                       out_custom;
  logic [rfl_pkg::OfsW-1:0]   out_total;
  logic [rfl_pkg::CountW-1:0] out_count;
  logic [1:0]                 out_status;
  logic                       out_last;

  record_field_layout #(
    .MAX_FIELDS(NumFields)
  ) u_top (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_valid_i            (cfg_valid),
    .cfg_ready_o            (cfg_ready),
    .cfg_index_i            (cfg_index),
    .cfg_data_i             (cfg_data),
    .in_valid_i             (in_valid),
    .in_stall_o             (in_stall),
    .in_op_i                (in_op),
    .in_field_size_i        (in_size),
    .in_field_align_i       (in_align),
    .in_raw_copy_safe_i     (in_raw),
    .out_valid_o            (out_valid),
    .out_stall_i            (out_stall),
    .out_field_index_o      (out_index),
    .out_field_offset_o     (out_offset),
    .out_needs_custom_copy_o(out_custom),
    .out_total_size_o       (out_total),
    .out_field_count_o      (out_count),
    .out_status_o           (out_status),
    .out_last_o             (out_last)
  );

  // --------------------------------------------------------------------------
  // Bench copy of the layout state and of the two registers.
  // --------------------------------------------------------------------------
  logic                       cfg_optimize  = 1'b0;
  logic [rfl_pkg::AlignW-1:0] cfg_max_align = rfl_pkg::MaxAlignReset;

  logic [rfl_pkg::SizeW-1:0]  fld_size  [NumFields];
  logic [rfl_pkg::AlignW-1:0] fld_align [NumFields];
  logic                       fld_raw   [NumFields];
  int unsigned                fld_ofs   [NumFields];
  int unsigned                n_loaded  = 0;
  bit                         overflowed = 1'b0;

  field_cmd_t    pending_cmds_q[$];    // items waiting for the driver
  rfl_pkg::res_t expected_layout_q[$]; // results predicted but not yet seen
  field_cmd_t    offered;              // item currently on the input channel

  int mismatch_count = 0;
  int send_idle_pct  = 30;
  int recv_idle_pct  = 84;
  logic recv_hold    = 1'b0;

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic bit align_legal(input logic [rfl_pkg::AlignW-1:0] a);
    return a != '0 && (a & (a - 1'b1)) == '0 && a <= cfg_max_align;
  endfunction

  // Rounds the running offset up to the field's alignment, records where the
  // field lands and moves past it.
  function automatic int unsigned place_field(input int unsigned run, input int i);
    int unsigned a;
    a = int'(fld_align[i]);
    run = (run + a - 1) & ~(a - 1);
    fld_ofs[i] = run;
    return run + int'(fld_size[i]);
  endfunction

  function automatic rfl_pkg::res_t error_result(input rfl_pkg::status_e st);
    rfl_pkg::res_t r;
    r = '0;
    r.field_count = rfl_pkg::CountW'(n_loaded);
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // Applies one accepted item to the bench state. An append only stores the
  // descriptor; a finish works out the whole layout and queues its results.
  task automatic apply_layout_cmd(input field_cmd_t c);
    int unsigned   run;
    int unsigned   total;
    bit            bad;
    rfl_pkg::res_t r;
    if (c.op == rfl_pkg::OpAppend) begin
      if (n_loaded < NumFields) begin
        fld_size[n_loaded]  = c.size;
        fld_align[n_loaded] = c.align;
        fld_raw[n_loaded]   = c.raw_safe;
        n_loaded++;
      end else begin
        overflowed = 1'b1;
      end
      return;
    end
    bad = 1'b0;
    for (int i = 0; i < n_loaded; i++) begin
      if (!align_legal(fld_align[i])) bad = 1'b1;
    end
    // Too many fields outranks a bad alignment.
    if (overflowed) begin
      expected_layout_q.insert(expected_layout_q.size(), error_result(rfl_pkg::StTooMany));
    end else if (bad) begin
      expected_layout_q.insert(expected_layout_q.size(), error_result(rfl_pkg::StBadAlign));
    end else begin
      run = int'(rfl_pkg::HeaderBytes);
      if (cfg_optimize) begin
        // Largest alignment first; within one class the load order holds.
        for (int cls = rfl_pkg::NumCls - 1; cls >= 0; cls--) begin
          for (int i = 0; i < n_loaded; i++) begin
            if (int'(fld_align[i]) == (1 << cls)) run = place_field(run, i);
          end
        end
      end else begin
        for (int i = 0; i < n_loaded; i++) run = place_field(run, i);
      end
      total = (run + 7) & ~32'd7;
      if (total > int'(rfl_pkg::TotalMax)) total = int'(rfl_pkg::TotalMax);
      if (n_loaded == 0) begin
        r = '0;
        r.total_size = rfl_pkg::OfsW'(total);
        r.status = rfl_pkg::StOk;
        r.last = 1'b1;
        expected_layout_q.insert(expected_layout_q.size(), r);
      end
      for (int i = 0; i < n_loaded; i++) begin
        r.field_index       = rfl_pkg::IndexW'(i);
        r.field_offset      = (fld_ofs[i] > int'(rfl_pkg::OfsMax)) ?
                              rfl_pkg::OfsMax : rfl_pkg::OfsW'(fld_ofs[i]);
        r.needs_custom_copy = ~fld_raw[i];
        r.total_size        = rfl_pkg::OfsW'(total);
        r.field_count       = rfl_pkg::CountW'(n_loaded);
        r.status            = rfl_pkg::StOk;
        r.last              = (i + 1 == n_loaded);
        expected_layout_q.insert(expected_layout_q.size(), r);
      end
    end
    // Every finish, good or bad, starts a fresh layout.
    n_loaded = 0;
    overflowed = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Driver: predicts each accepted item, then either presents the next one
  // or idles. A stalled item is held unchanged until it is accepted.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_layout_cmd(offered);
      if (!in_valid || !in_stall) begin
        if (pending_cmds_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered   = pending_cmds_q.pop_front();
          in_valid <= 1'b1;
          in_op    <= offered.op;
          in_size  <= offered.size;
          in_align <= offered.align;
          in_raw   <= offered.raw_safe;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_error($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Monitor: every result transfer is checked against the oldest prediction.
  // The stall is random, and forced high while a long hold-off is running.
  // --------------------------------------------------------------------------
  rfl_pkg::res_t want_r;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_layout_q.size() == 0) begin
          report_error($sformatf("result for field %0d with none expected", out_index));
        end else begin
          want_r = expected_layout_q.pop_front();
          check_field("field_index", 32'(out_index), 32'(want_r.field_index));
          check_field("field_offset", 32'(out_offset), 32'(want_r.field_offset));
          check_field("needs_custom_copy", 32'(out_custom), 32'(want_r.needs_custom_copy));
          check_field("total_size", 32'(out_total), 32'(want_r.total_size));
          check_field("field_count", 32'(out_count), 32'(want_r.field_count));
          check_field("status", 32'(out_status), 32'(want_r.status));
          check_field("last", 32'(out_last), 32'(want_r.last));
        end
      end
      out_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  int queued_items = 0;

  task automatic push_cmd(input logic op, input int size, input int align, input logic raw);
    field_cmd_t c;
    c.op = op;
    c.size = rfl_pkg::SizeW'(size);
    c.align = rfl_pkg::AlignW'(align);
    c.raw_safe = raw;
    pending_cmds_q.insert(pending_cmds_q.size(), c);
    queued_items++;
  endtask

  // A finish carries random payload bits, which the block must ignore.
  task automatic push_finish();
    push_cmd(rfl_pkg::OpFinish, $urandom_range(65535), $urandom_range(8191),
             $urandom_range(1));
  endtask

  // Queues one layout: a run of appends and a finish. Most layouts are well
  // formed for the current max_align, if it is nonzero; a broken one gets a single bad field.
  task automatic gen_layout(input int n_force, input bit force_broken);
    int n;
    int lg;
    int bad_at;
    int a;
    int size;
    lg = -1;
    for (int k = 0; k < rfl_pkg::NumCls; k++) begin
      if ((1 << k) <= int'(cfg_max_align)) lg = k;
    end
    if (n_force >= 0) begin
      n = n_force;
    end else begin
      case ($urandom_range(49))
        0, 1, 2, 3, 4:  n = 0;
        5, 6, 7, 8:     n = $urandom_range(32, 9);
        9:              n = $urandom_range(36, 33);
        default:        n = $urandom_range(8, 1);
      endcase
    end
    bad_at = (force_broken || $urandom_range(99) < 20) ? $urandom_range(n - 1) : -1;
    for (int i = 0; i < n; i++) begin
      if (i != bad_at && lg >= 0) begin
        a = 1 << $urandom_range(lg, 0);
      end else begin
        case ($urandom_range(3))
          0:       a = 0;
          1:       a = $urandom_range(8191);
          2:       a = (lg < 12) ? (1 << $urandom_range(12, lg + 1)) : 8191;
          default: a = (1 << $urandom_range(12, 1)) | 1;
        endcase
      end
      size = ($urandom_range(99) < 70) ? $urandom_range(64) : $urandom_range(65535);
      push_cmd(rfl_pkg::OpAppend, size, a, $urandom_range(1));
    end
    push_finish();
  endtask

  // Writes one register over the configuration channel and mirrors it.
  task automatic write_cfg(input logic [rfl_pkg::CfgIdxW-1:0] idx, input int value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= rfl_pkg::CfgDataW'(value);
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == rfl_pkg::CfgOptimize) cfg_optimize = value[0];
    else if (idx == rfl_pkg::CfgMaxAlign) cfg_max_align = rfl_pkg::AlignW'(value);
  endtask

  // The sender pauses here until everything queued has been sent and every
  // predicted result has arrived, then lets trailing appends settle.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_cmds_q.size() != 0 || in_valid || expected_layout_q.size() != 0);
    repeat (TailCycles) @(negedge clk_i);
  endtask

  task automatic run_random(input int budget);
    int stop_at;
    stop_at = queued_items + budget;
    while (queued_items < stop_at) gen_layout(-1, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part with the reset settings (load order, max_align 16).
    push_finish();                              // empty layout
    push_cmd(rfl_pkg::OpAppend, 65535, 16, 1'b0);
    push_cmd(rfl_pkg::OpAppend, 0, 1, 1'b1);
    push_cmd(rfl_pkg::OpAppend, 3, 2, 1'b1);
    push_cmd(rfl_pkg::OpAppend, 1, 8, 1'b0);
    push_cmd(rfl_pkg::OpAppend, 7, 4, 1'b1);
    push_finish();                              // well-formed layout
    push_cmd(rfl_pkg::OpAppend, 5, 0, 1'b1);
    push_finish();                              // zero alignment
    push_cmd(rfl_pkg::OpAppend, 4, 4, 1'b1);
    push_cmd(rfl_pkg::OpAppend, 9, 12, 1'b0);
    push_finish();                              // not a power of two
    push_cmd(rfl_pkg::OpAppend, 8, 32, 1'b1);
    push_finish();                              // above max_align
    push_cmd(rfl_pkg::OpAppend, 65535, 8191, 1'b0);
    push_finish();                              // every alignment bit set
    run_random(30);
    wait_drained();

    // Reordered placement with the largest accepted alignment. The first
    // layout overflows the table and also holds a bad alignment.
    write_cfg(rfl_pkg::CfgOptimize, 1);
    write_cfg(rfl_pkg::CfgMaxAlign, 4096);
    write_cfg(CfgSpareLo, 8191);
    @(negedge clk_i);
    gen_layout(34, 1'b1);
    gen_layout(32, 1'b0);
    run_random(60);
    wait_drained();

    // A max_align of zero rejects every alignment.
    write_cfg(rfl_pkg::CfgMaxAlign, 0);
    @(negedge clk_i);
    run_random(20);
    wait_drained();

    // Swap the idling: the sender now idles more than the receiver.
    send_idle_pct = 84;
    recv_idle_pct = 30;
    write_cfg(rfl_pkg::CfgOptimize, 0);
    write_cfg(rfl_pkg::CfgMaxAlign, 1);
    write_cfg(CfgSpareHi, 0);
    @(negedge clk_i);
    run_random(35);
    wait_drained();

    write_cfg(rfl_pkg::CfgOptimize, 1);
    write_cfg(rfl_pkg::CfgMaxAlign, 8191);
    @(negedge clk_i);
    run_random(55);
    wait_drained();

    // No idling. The receiver holds off for a long stretch while the sender
    // keeps offering, so the block fills up and stalls its input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_cfg(rfl_pkg::CfgOptimize, 0);
    write_cfg(rfl_pkg::CfgMaxAlign, 4096);
    @(negedge clk_i);
    fork
      begin
        recv_hold <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        recv_hold <= 1'b0;
      end
    join_none
    gen_layout(32, 1'b0);
    gen_layout(32, 1'b0);
    run_random(30);
    wait_drained();

    write_cfg(rfl_pkg::CfgOptimize, 1);
    write_cfg(rfl_pkg::CfgMaxAlign, rfl_pkg::MaxAlignReset);
    @(negedge clk_i);
    run_random(65);
    wait_drained();

    if (expected_layout_q.size() != 0) begin
      report_error($sformatf("%0d results never arrived", expected_layout_q.size()));
    end
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog, sized well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

`default_nettype wire
